[rtl/ddcs_pkg.sv]
// ----------------------------------------------------------------------------
// ddcs_pkg
// Types, register indexes and helpers for the differential drive command
// shaper.
// ----------------------------------------------------------------------------
package ddcs_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_LINEAR_SPEED = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TURN_RATE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_STEP      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_STEP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_RADIUS   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_WHEEL_SPEED  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL_STEP       = 3'd7;

    typedef struct packed {
        logic signed [31:0] speed_cmd;
        logic signed [31:0] turn_cmd;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] left_wheel_drive;
        logic signed [31:0] right_wheel_drive;
        logic signed [31:0] left_wheel_goal;
        logic signed [31:0] right_wheel_goal;
        logic signed [31:0] applied_speed;
        logic signed [31:0] applied_turn;
    } out_item_t;

    // symmetric clamp to +/- bound; result always fits 32 bits
    function automatic logic signed [31:0] clamp_sym(input logic signed [64:0] x,
                                                     input logic [30:0] bound);
        logic signed [64:0] pos;
        logic signed [64:0] neg;
        pos = $signed({34'b0, bound});
        neg = -pos;
        if (x > pos) begin
            return pos[31:0];
        end else if (x < neg) begin
            return neg[31:0];
        end else begin
            return x[31:0];
        end
    endfunction

    function automatic logic signed [64:0] sext32(input logic signed [31:0] x);
        return {{33{x[31]}}, x};
    endfunction

    // move held at most one step toward target
    function automatic logic signed [31:0] slew(input logic signed [31:0] held,
                                                input logic signed [31:0] target,
                                                input logic [30:0] step);
        logic signed [64:0] diff;
        logic signed [31:0] d;
        diff = sext32(target) - sext32(held);
        d    = clamp_sym(diff, step);
        return held + d;
    endfunction

endpackage

[rtl/diff_drive_command_shaper.sv]
// ----------------------------------------------------------------------------
// diff_drive_command_shaper
// Clamp and slew limit of a speed / yaw command, differential drive
// kinematics, wheel clamp and wheel slew limit, all Q15.16.
// ----------------------------------------------------------------------------
// An accepted item steps through the slew, yaw product, wheel base, wheel
// product, goal and wheel slew states before its result is loaded into the
// output register; the load waits while the result channel stalls the previous
// result, and the next item is accepted after that load. One shared 49-bit signed by
// 16-bit unsigned multiplier handles the yaw times half track product and both
// wheel products as two 16-bit partial products each, accumulated in one wide
// register. s_ready is high only while the sequencer is idle; a finished result
// waits in the output register while the next item is taken.
module diff_drive_command_shaper (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ddcs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ddcs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ddcs_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ddcs_pkg::out_item_t                 m_data
);
    import ddcs_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SLEW  = 4'd1;
    localparam logic [3:0] ST_T0    = 4'd2;
    localparam logic [3:0] ST_T1    = 4'd3;
    localparam logic [3:0] ST_T2    = 4'd4;
    localparam logic [3:0] ST_BASE  = 4'd5;
    localparam logic [3:0] ST_L0    = 4'd6;
    localparam logic [3:0] ST_L1    = 4'd7;
    localparam logic [3:0] ST_L2    = 4'd8;
    localparam logic [3:0] ST_R1    = 4'd9;
    localparam logic [3:0] ST_R2    = 4'd10;
    localparam logic [3:0] ST_GOAL  = 4'd11;
    localparam logic [3:0] ST_WHEEL = 4'd12;
    localparam logic [3:0] ST_OUT   = 4'd13;

    logic [30:0] max_linear_speed_reg, max_turn_rate_reg, linear_step_reg, turn_step_reg;
    logic [30:0] half_track_reg, inverse_radius_reg, max_wheel_speed_reg, wheel_step_reg;

    logic [3:0]         state_reg, state_next;
    logic signed [31:0] cmd_v_reg, cmd_v_next, cmd_w_reg, cmd_w_next;
    logic signed [31:0] held_speed_reg, held_speed_next, held_turn_reg, held_turn_next;
    logic signed [31:0] held_left_reg, held_left_next, held_right_reg, held_right_next;
    logic signed [31:0] gl_reg, gl_next, gr_reg, gr_next;
    logic signed [48:0] la_reg, la_next, ra_reg, ra_next;
    logic signed [65:0] prod_reg, prod_next;
    logic signed [80:0] acc_reg, acc_next;
    logic               m_valid_reg, m_valid_next;
    out_item_t          m_data_reg, m_data_next;

    logic signed [48:0] mul_a;
    logic [15:0]        mul_b;
    logic signed [46:0] yt;
    logic signed [80:0] prod_ext;
    logic signed [31:0] acc_clamped;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // floor(x / 2^16) is the arithmetic shift, i.e. the upper slice
    assign yt          = acc_reg[62:16];
    assign prod_ext    = {{15{prod_reg[65]}}, prod_reg};
    assign acc_clamped = clamp_sym($signed(acc_reg[80:16]), max_wheel_speed_reg);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_T0: begin
                mul_a = {{17{held_turn_reg[31]}}, held_turn_reg};
                mul_b = {1'b0, half_track_reg[30:16]};
            end
            ST_T1: begin
                mul_a = {{17{held_turn_reg[31]}}, held_turn_reg};
                mul_b = half_track_reg[15:0];
            end
            ST_L0: begin
                mul_a = la_reg;
                mul_b = {1'b0, inverse_radius_reg[30:16]};
            end
            ST_L1: begin
                mul_a = la_reg;
                mul_b = inverse_radius_reg[15:0];
            end
            ST_L2: begin
                mul_a = ra_reg;
                mul_b = {1'b0, inverse_radius_reg[30:16]};
            end
            ST_R1: begin
                mul_a = ra_reg;
                mul_b = inverse_radius_reg[15:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 66'(mul_a) * 66'($signed({1'b0, mul_b}));

    always_comb begin
        state_next      = state_reg;
        cmd_v_next      = cmd_v_reg;
        cmd_w_next      = cmd_w_reg;
        held_speed_next = held_speed_reg;
        held_turn_next  = held_turn_reg;
        held_left_next  = held_left_reg;
        held_right_next = held_right_reg;
        gl_next         = gl_reg;
        gr_next         = gr_reg;
        la_next         = la_reg;
        ra_next         = ra_reg;
        acc_next        = acc_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd_v_next = clamp_sym(sext32(s_data.speed_cmd),
                                           max_linear_speed_reg);
                    cmd_w_next = clamp_sym(sext32(s_data.turn_cmd), max_turn_rate_reg);
                    state_next = ST_SLEW;
                end
            end
            ST_SLEW: begin
                held_speed_next = slew(held_speed_reg, cmd_v_reg, linear_step_reg);
                held_turn_next  = slew(held_turn_reg, cmd_w_reg, turn_step_reg);
                state_next      = ST_T0;
            end
            ST_T0: state_next = ST_T1;
            ST_T1: begin
                acc_next   = prod_ext;
                state_next = ST_T2;
            end
            ST_T2: begin
                acc_next   = (acc_reg <<< 16) + prod_ext;
                state_next = ST_BASE;
            end
            ST_BASE: begin
                la_next    = {{17{held_speed_reg[31]}}, held_speed_reg} - {{2{yt[46]}}, yt};
                ra_next    = {{17{held_speed_reg[31]}}, held_speed_reg} + {{2{yt[46]}}, yt};
                state_next = ST_L0;
            end
            ST_L0: state_next = ST_L1;
            ST_L1: begin
                acc_next   = prod_ext;
                state_next = ST_L2;
            end
            ST_L2: begin
                acc_next   = (acc_reg <<< 16) + prod_ext;
                state_next = ST_R1;
            end
            ST_R1: begin
                // left product complete in acc; right high partial is in prod
                gl_next    = acc_clamped;
                acc_next   = prod_ext;
                state_next = ST_R2;
            end
            ST_R2: begin
                acc_next   = (acc_reg <<< 16) + prod_ext;
                state_next = ST_GOAL;
            end
            ST_GOAL: begin
                gr_next    = acc_clamped;
                state_next = ST_WHEEL;
            end
            ST_WHEEL: begin
                held_left_next  = slew(held_left_reg, gl_reg, wheel_step_reg);
                held_right_next = slew(held_right_reg, gr_reg, wheel_step_reg);
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next                  = 1'b1;
                    m_data_next.left_wheel_drive  = held_left_reg;
                    m_data_next.right_wheel_drive = held_right_reg;
                    m_data_next.left_wheel_goal   = gl_reg;
                    m_data_next.right_wheel_goal  = gr_reg;
                    m_data_next.applied_speed     = held_speed_reg;
                    m_data_next.applied_turn      = held_turn_reg;
                    state_next                    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            held_speed_reg <= '0;
            held_turn_reg  <= '0;
            held_left_reg  <= '0;
            held_right_reg <= '0;
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            held_speed_reg <= held_speed_next;
            held_turn_reg  <= held_turn_next;
            held_left_reg  <= held_left_next;
            held_right_reg <= held_right_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_v_reg  <= cmd_v_next;
        cmd_w_reg  <= cmd_w_next;
        gl_reg     <= gl_next;
        gr_reg     <= gr_next;
        la_reg     <= la_next;
        ra_reg     <= ra_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_linear_speed_reg <= '0;
            max_turn_rate_reg    <= '0;
            linear_step_reg      <= '0;
            turn_step_reg        <= '0;
            half_track_reg       <= '0;
            inverse_radius_reg   <= '0;
            max_wheel_speed_reg  <= '0;
            wheel_step_reg       <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MAX_LINEAR_SPEED: max_linear_speed_reg <= cfg_wdata;
                REG_MAX_TURN_RATE:    max_turn_rate_reg    <= cfg_wdata;
                REG_LINEAR_STEP:      linear_step_reg      <= cfg_wdata;
                REG_TURN_STEP:        turn_step_reg        <= cfg_wdata;
                REG_HALF_TRACK:       half_track_reg       <= cfg_wdata;
                REG_INVERSE_RADIUS:   inverse_radius_reg   <= cfg_wdata;
                REG_MAX_WHEEL_SPEED:  max_wheel_speed_reg  <= cfg_wdata;
                REG_WHEEL_STEP:       wheel_step_reg       <= cfg_wdata;
                default: ;
            endcase
        end
    end

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for diff_drive_command_shaper. Velocity commands go in
// over a valid/ready channel with random gaps. Each result is checked field by
// field against an in-bench model of the clamp, slew, kinematics and wheel
// limit path. Directed cases come first, then random traffic over several
// register settings.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ddcs_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int TAIL_CYCLES  = 30;

    localparam logic signed [31:0] CMD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] CMD_MIN = 32'sh8000_0000;
    localparam logic [30:0]        REG_TOP = 31'h7FFF_FFFF;

    typedef logic [30:0] reg_set_t [8];

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;

    // shadow of the register file and the held values
    logic [30:0] shadow_regs [8];
    longint      held_speed_m;
    longint      held_turn_m;
    longint      held_left_m;
    longint      held_right_m;

    out_item_t   drive_expect_q [$];
    int          mismatch_count;
    int          results_seen;
    bit          no_gaps;

    diff_drive_command_shaper i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------- model

    function automatic longint clip(longint x, longint bound);
        if (x > bound) begin
            return bound;
        end
        if (x < -bound) begin
            return -bound;
        end
        return x;
    endfunction

    function automatic longint ramp(longint held, longint target, longint step);
        return held + clip(target - held, step);
    endfunction

    // (speed -/+ yaw offset) * inverse radius, floored back to Q15.16
    function automatic longint wheel_scale(longint base);
        logic signed [95:0] prod;
        logic signed [95:0] scaled;
        if (shadow_regs[REG_INVERSE_RADIUS] == '0) begin
            return 0;
        end
        prod   = 96'(base);
        prod   = prod * $signed({65'd0, shadow_regs[REG_INVERSE_RADIUS]});
        scaled = prod >>> 16;
        return clip(scaled[63:0], longint'(shadow_regs[REG_MAX_WHEEL_SPEED]));
    endfunction

    function automatic out_item_t shape_command(in_item_t cmd);
        longint    v;
        longint    w;
        longint    yaw_offset;
        longint    goal_l;
        longint    goal_r;
        out_item_t res;
        v = clip(longint'(cmd.speed_cmd), longint'(shadow_regs[REG_MAX_LINEAR_SPEED]));
        w = clip(longint'(cmd.turn_cmd), longint'(shadow_regs[REG_MAX_TURN_RATE]));
        held_speed_m = ramp(held_speed_m, v, longint'(shadow_regs[REG_LINEAR_STEP]));
        held_turn_m  = ramp(held_turn_m, w, longint'(shadow_regs[REG_TURN_STEP]));
        yaw_offset = (held_turn_m * longint'(shadow_regs[REG_HALF_TRACK])) >>> 16;
        goal_l = wheel_scale(held_speed_m - yaw_offset);
        goal_r = wheel_scale(held_speed_m + yaw_offset);
        held_left_m  = ramp(held_left_m, goal_l, longint'(shadow_regs[REG_WHEEL_STEP]));
        held_right_m = ramp(held_right_m, goal_r, longint'(shadow_regs[REG_WHEEL_STEP]));
        res.left_wheel_drive  = held_left_m[31:0];
        res.right_wheel_drive = held_right_m[31:0];
        res.left_wheel_goal   = goal_l[31:0];
        res.right_wheel_goal  = goal_r[31:0];
        res.applied_speed     = held_speed_m[31:0];
        res.applied_turn      = held_turn_m[31:0];
        return res;
    endfunction

    // ------------------------------------------------------------ checking

    task automatic report_mismatch(string msg);
        $display("tb: mismatch on result %0d: %s", results_seen, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (drive_expect_q.size() == 0) begin
            report_mismatch("result with nothing expected");
        end else begin
            want = drive_expect_q.pop_front();
            check_field("left_wheel_drive", got.left_wheel_drive, want.left_wheel_drive);
            check_field("right_wheel_drive", got.right_wheel_drive,
                        want.right_wheel_drive);
            check_field("left_wheel_goal", got.left_wheel_goal, want.left_wheel_goal);
            check_field("right_wheel_goal", got.right_wheel_goal, want.right_wheel_goal);
            check_field("applied_speed", got.applied_speed, want.applied_speed);
            check_field("applied_turn", got.applied_turn, want.applied_turn);
        end
        results_seen++;
    endtask

    // result side: random stall after every item
    initial begin
        int stall;
        stall = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                check_result(m_data);
                stall = no_gaps ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ends the run when nothing moves for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------- drivers

    // valid is left high after acceptance so back-to-back items need one NBA
    task automatic send_command(in_item_t cmd);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        drive_expect_q.push_back(shape_command(cmd));
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (drive_expect_q.size() != 0) @(posedge aclk);
    endtask

    task automatic load_config(reg_set_t vals);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            shadow_regs[i] = vals[i];
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_pair(logic signed [31:0] lin, logic signed [31:0] yaw);
        in_item_t cmd;
        cmd.speed_cmd = lin;
        cmd.turn_cmd  = yaw;
        send_command(cmd);
    endtask

    function automatic logic signed [31:0] pick_edge();
        case ($urandom_range(0, 4))
            0:       return CMD_MAX;
            1:       return CMD_MIN;
            2:       return 32'sd0;
            3:       return -32'sd1;
            default: return 32'sd1;
        endcase
    endfunction

    // log-uniform magnitude so small and huge values both show up
    function automatic logic signed [31:0] pick_scaled();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    function automatic logic [30:0] draw_reg_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return REG_TOP;
            default: return 31'($urandom >> $urandom_range(1, 31));
        endcase
    endfunction

    function automatic in_item_t draw_command(in_item_t prev);
        in_item_t c;
        case ($urandom_range(0, 9))
            0, 1: c = prev;    // held command lets the slew limiters settle
            2: begin
                c.speed_cmd = $urandom;
                c.turn_cmd  = $urandom;
            end
            3: begin
                c.speed_cmd = pick_edge();
                c.turn_cmd  = pick_edge();
            end
            default: begin
                c.speed_cmd = pick_scaled();
                c.turn_cmd  = pick_scaled();
            end
        endcase
        return c;
    endfunction

    // --------------------------------------------------------------- tests

    // all registers zero: every bound and step is zero, so all outputs stay 0
    task automatic test_zero_config();
        reg_set_t regs;
        regs = '{default: '0};
        load_config(regs);
        send_pair(CMD_MAX, CMD_MIN);
        send_pair(CMD_MIN, CMD_MAX);
        send_pair(-32'sd1, 32'sd1);
        wait_drained();
    endtask

    // every register at full scale: huge products, wheel clamp saturates
    task automatic test_full_scale();
        reg_set_t regs;
        regs = '{default: REG_TOP};
        load_config(regs);
        send_pair(CMD_MAX, CMD_MAX);
        send_pair(CMD_MIN, CMD_MIN);
        send_pair(CMD_MAX, CMD_MIN);
        send_pair(CMD_MIN, CMD_MAX);
        send_pair(32'sd0, 32'sd0);
        send_pair(32'sd1, -32'sd1);
        wait_drained();
    endtask

    task automatic test_zero_radius();
        reg_set_t regs;
        regs = '{default: REG_TOP};
        regs[REG_MAX_LINEAR_SPEED] = 31'h0004_0000;
        regs[REG_MAX_TURN_RATE]    = 31'h0002_0000;
        regs[REG_LINEAR_STEP]      = 31'h0000_4000;
        regs[REG_TURN_STEP]        = 31'h0000_2000;
        regs[REG_HALF_TRACK]       = 31'h0000_2000;
        regs[REG_INVERSE_RADIUS]   = '0;
        regs[REG_MAX_WHEEL_SPEED]  = 31'h0040_0000;
        regs[REG_WHEEL_STEP]       = 31'h0001_0000;
        load_config(regs);
        send_pair(32'sh0010_0000, -32'sh0010_0000);
        send_pair(32'sh0010_0000, -32'sh0010_0000);
        send_pair(32'sh0010_0000, -32'sh0010_0000);
        send_pair(-32'sd7, 32'sd5);
        wait_drained();
    endtask

    // zero steps freeze applied speed, turn and both wheel drives
    task automatic test_zero_steps();
        reg_set_t regs;
        regs = '{default: REG_TOP};
        regs[REG_LINEAR_STEP]     = '0;
        regs[REG_TURN_STEP]       = '0;
        regs[REG_HALF_TRACK]      = 31'h0000_2000;
        regs[REG_INVERSE_RADIUS]  = 31'h0010_0000;
        regs[REG_MAX_WHEEL_SPEED] = 31'h0100_0000;
        regs[REG_WHEEL_STEP]      = '0;
        load_config(regs);
        send_pair(CMD_MIN, CMD_MAX);
        send_pair(32'sh0003_0000, 32'sh0001_0000);
        send_pair(32'sd0, 32'sd0);
        wait_drained();
    endtask

    // zero wheel bound forces both wheel goals to 0
    task automatic test_zero_wheel_bound();
        reg_set_t regs;
        regs = '{default: REG_TOP};
        regs[REG_HALF_TRACK]      = 31'h0000_8000;
        regs[REG_INVERSE_RADIUS]  = 31'h0001_0000;
        regs[REG_MAX_WHEEL_SPEED] = '0;
        load_config(regs);
        send_pair(32'sh0002_0000, 32'sh0001_0000);
        send_pair(CMD_MAX, CMD_MIN);
        send_pair(32'sd0, -32'sd3);
        wait_drained();
    endtask

    // tiny scale factors: small negative products must floor to -1, not 0
    task automatic test_floor_rounding();
        reg_set_t regs;
        regs = '{default: REG_TOP};
        regs[REG_HALF_TRACK]     = 31'd1;
        regs[REG_INVERSE_RADIUS] = 31'd1;
        load_config(regs);
        send_pair(-32'sd1, -32'sd3);
        send_pair(32'sd3, -32'sd5);
        send_pair(-32'sd100000, 32'sd7);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        reg_set_t regs;
        in_item_t cmd;
        for (int phase = 0; phase < 10; phase++) begin
            foreach (regs[i]) regs[i] = draw_reg_value();
            load_config(regs);
            cmd = '0;
            for (int n = 0; n < 200; n++) begin
                if (n % 50 == 0) begin
                    no_gaps = ($urandom_range(0, 3) == 0);
                end
                cmd = draw_command(cmd);
                send_command(cmd);
            end
            no_gaps = 1'b0;
            wait_drained();
        end
    endtask

    // ---------------------------------------------------------------- main

    initial begin
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        foreach (shadow_regs[i]) shadow_regs[i] = '0;
        held_speed_m   = 0;
        held_turn_m    = 0;
        held_left_m    = 0;
        held_right_m   = 0;
        mismatch_count = 0;
        results_seen   = 0;
        no_gaps        = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_config();
        test_full_scale();
        test_zero_radius();
        test_zero_steps();
        test_zero_wheel_bound();
        test_floor_rounding();
        test_random_traffic();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && drive_expect_q.size() == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
